### rtl/absp_pkg.sv
// ----------------------------------------------------------------------------
// absp_pkg
// Shared types and constants for the buffered serial port: operation codes,
// register selects, transmit modes, control and status bits, buffer sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package absp_pkg;

   // buffer sizes
   localparam int RX_DEPTH = 256;
   localparam int TX_DEPTH = 64;

   localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int TX_CW = $clog2(TX_DEPTH + 1);

   // item operations
   typedef enum logic [1:0] {
      OP_BUS_READ  = 2'd0,
      OP_BUS_WRITE = 2'd1,
      OP_HOST_RX   = 2'd2
   } absp_op_type;

   // register selects
   localparam logic REG_CTRL = 1'b0;
   localparam logic REG_DATA = 1'b1;

   // transmit buffering modes (the unused code behaves as until full)
   typedef enum logic [1:0] {
      TXM_LINE = 2'd0,
      TXM_FULL = 2'd1,
      TXM_NONE = 2'd2
   } absp_tx_mode_type;

   // control write bits
   localparam int CTRL_IRQ_EN_BIT = 7;
   localparam int CTRL_FLUSH_BIT  = 2;

   // status read bits
   localparam logic [7:0] STAT_IRQ   = 8'h80;
   localparam logic [7:0] STAT_RX    = 8'h01;
   localparam logic [7:0] CHAR_NL    = 8'h0A;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RX_READ,
      ST_TX_READ,
      ST_TX_SEND
   } absp_state_type;

   // commands to the receive buffer
   typedef struct packed {
      logic push;
      logic chunk_end;
      logic pop;
   } absp_rx_cmd_type;

   // receive buffer status
   typedef struct packed {
      logic data_present;
      logic can_take;
      logic fill_last;
   } absp_rx_status_type;

endpackage

`default_nettype wire

### rtl/acia_buffered_serial_port_unit.sv
// ----------------------------------------------------------------------------
// acia_buffered_serial_port_unit
// Two-register serial port: status/control and data registers on the bus side,
// chunked receive buffer loaded by the host, transmit buffer drained to host.
//
//   channel | direction | ports                                    | transfer
//   req     | in        | operation, reg_select, data, rx_chunk_end | valid & !stall
//   rsp     | out       | read_data, irq_line, rx_accepted,          | valid & !stall
//           |           | tx_valid, tx_byte, tx_last                 |
//
// Plain items go back to back through a one-entry item register and the
// result register, while the result is not stalled. A data read that pops
// a byte loads its result from ST_RX_READ (receive store read port). A drain
// takes the item, then a store read and a send per byte; a stalled send waits.
// Reset clears all pointers, counts and flags at once; no clearing pass.
// A stalled result holds; one further item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module acia_buffered_serial_port_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_operation,
   input  wire         req_reg_select,
   input  wire  [7:0]  req_data,
   input  wire         req_rx_chunk_end,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_line,
   output logic        rsp_rx_accepted,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last
);

   // item register
   logic        item_valid_ff, item_valid_in;
   logic [1:0]  item_op_ff;
   logic        item_sel_ff;
   logic [7:0]  item_data_ff;
   logic        item_end_ff;
   logic        accept, take, out_free;

   // sequencer and port state
   absp_pkg::absp_state_type      state_ff, state_in;
   logic [absp_pkg::TX_CW-1:0]    tx_count_ff, tx_count_in;
   logic [1:0]                    tx_mode_ff, tx_mode_in;
   logic                          irq_en_ff, irq_en_in;
   logic                          irq_flag_ff, irq_flag_in;
   logic [absp_pkg::TX_AW-1:0]    drain_idx_ff, drain_idx_in;
   logic [absp_pkg::TX_AW-1:0]    drain_last_ff, drain_last_in;

   // transmit store
   logic [7:0]                    tx_mem [absp_pkg::TX_DEPTH];
   logic [7:0]                    tx_rd_data_ff;
   logic                          tx_we;
   logic [absp_pkg::TX_CW-1:0]    tx_count_inc;
   logic                          tx_go;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic        rsp_acc_ff, rsp_acc_in;
   logic        rsp_txv_ff, rsp_txv_in;
   logic [7:0]  rsp_txb_ff, rsp_txb_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_load;

   // receive buffer
   absp_pkg::absp_rx_cmd_type     rx_cmd;
   absp_pkg::absp_rx_status_type  rx_status;
   logic [7:0]                    rx_rd_data;

   absp_rx_buffer u_rx_buffer (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rx_cmd),
      .wr_data (item_data_ff),
      .status  (rx_status),
      .rd_data (rx_rd_data)
   );

   // handshakes
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign take          = item_valid_ff && (state_ff == absp_pkg::ST_IDLE) && out_free;
   assign req_stall     = item_valid_ff && !take;
   assign accept        = req_valid && !req_stall;
   assign item_valid_in = accept || (item_valid_ff && !take);
   assign tx_count_inc  = tx_count_ff + absp_pkg::TX_CW'(1);

   // transmit drain decision on a data write
   always_comb begin
      unique case (tx_mode_ff)
         absp_pkg::TXM_NONE: tx_go = 1'b1;
         absp_pkg::TXM_LINE: tx_go = (item_data_ff == absp_pkg::CHAR_NL) ||
                                     (tx_count_inc == absp_pkg::TX_CW'(absp_pkg::TX_DEPTH));
         default:            tx_go = (tx_count_inc == absp_pkg::TX_CW'(absp_pkg::TX_DEPTH));
      endcase
   end

   // sequencer: next state and result loading
   always_comb begin
      state_in         = state_ff;
      tx_count_in      = tx_count_ff;
      tx_mode_in       = tx_mode_ff;
      irq_en_in        = irq_en_ff;
      irq_flag_in      = irq_flag_ff;
      drain_idx_in     = drain_idx_ff;
      drain_last_in    = drain_last_ff;
      tx_we            = 1'b0;
      rx_cmd           = '0;
      out_load         = 1'b0;
      rsp_read_data_in = '0;
      rsp_acc_in       = 1'b0;
      rsp_txv_in       = 1'b0;
      rsp_txb_in       = '0;
      rsp_last_in      = 1'b1;
      unique case (state_ff)
         absp_pkg::ST_IDLE: begin
            if (take) begin
               out_load = 1'b1;
               unique case (item_op_ff)
                  absp_pkg::OP_BUS_READ: begin
                     if (item_sel_ff == absp_pkg::REG_CTRL) begin
                        rsp_read_data_in = (irq_flag_ff ? absp_pkg::STAT_IRQ : 8'h00) |
                                           (rx_status.data_present ? absp_pkg::STAT_RX
                                                                   : 8'h00);
                        irq_flag_in = 1'b0;
                     end else if (rx_status.data_present) begin
                        rx_cmd.pop = 1'b1;
                        out_load   = 1'b0;
                        state_in   = absp_pkg::ST_RX_READ;
                     end
                  end
                  absp_pkg::OP_BUS_WRITE: begin
                     if (item_sel_ff == absp_pkg::REG_CTRL) begin
                        if (item_data_ff[absp_pkg::CTRL_IRQ_EN_BIT]) begin
                           irq_en_in = 1'b1;
                        end
                        tx_mode_in = item_data_ff[1:0];
                        if (item_data_ff[absp_pkg::CTRL_FLUSH_BIT] &&
                            (tx_count_ff != '0)) begin
                           out_load      = 1'b0;
                           tx_count_in   = '0;
                           drain_idx_in  = '0;
                           drain_last_in = absp_pkg::TX_AW'(tx_count_ff - absp_pkg::TX_CW'(1));
                           state_in      = absp_pkg::ST_TX_READ;
                        end
                     end else begin
                        tx_we       = 1'b1;
                        tx_count_in = tx_count_inc;
                        if (tx_go) begin
                           out_load      = 1'b0;
                           tx_count_in   = '0;
                           drain_idx_in  = '0;
                           drain_last_in = absp_pkg::TX_AW'(tx_count_ff);
                           state_in      = absp_pkg::ST_TX_READ;
                        end
                     end
                  end
                  absp_pkg::OP_HOST_RX: begin
                     if (rx_status.can_take) begin
                        rx_cmd.push      = 1'b1;
                        rx_cmd.chunk_end = item_end_ff;
                        rsp_acc_in       = 1'b1;
                        if ((item_end_ff || rx_status.fill_last) && irq_en_ff) begin
                           irq_flag_in = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         absp_pkg::ST_RX_READ: begin
            out_load         = 1'b1;
            rsp_read_data_in = rx_rd_data;
            state_in         = absp_pkg::ST_IDLE;
         end
         absp_pkg::ST_TX_READ: begin
            state_in = absp_pkg::ST_TX_SEND;
         end
         absp_pkg::ST_TX_SEND: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_txv_in  = 1'b1;
               rsp_txb_in  = tx_rd_data_ff;
               rsp_last_in = (drain_idx_ff == drain_last_ff);
               if (drain_idx_ff == drain_last_ff) begin
                  state_in = absp_pkg::ST_IDLE;
               end else begin
                  drain_idx_in = drain_idx_ff + absp_pkg::TX_AW'(1);
                  state_in     = absp_pkg::ST_TX_READ;
               end
            end
         end
         default: state_in = absp_pkg::ST_IDLE;
      endcase
      rsp_irq_in   = irq_flag_in;
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= absp_pkg::ST_IDLE;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tx_count_ff   <= '0;
         tx_mode_ff    <= absp_pkg::TXM_LINE;
         irq_en_ff     <= 1'b0;
         irq_flag_ff   <= 1'b0;
         drain_idx_ff  <= '0;
         drain_last_ff <= '0;
      end else begin
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tx_count_ff   <= tx_count_in;
         tx_mode_ff    <= tx_mode_in;
         irq_en_ff     <= irq_en_in;
         irq_flag_ff   <= irq_flag_in;
         drain_idx_ff  <= drain_idx_in;
         drain_last_ff <= drain_last_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff   <= req_operation;
         item_sel_ff  <= req_reg_select;
         item_data_ff <= req_data;
         item_end_ff  <= req_rx_chunk_end;
      end
      if (out_load) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_irq_ff       <= rsp_irq_in;
         rsp_acc_ff       <= rsp_acc_in;
         rsp_txv_ff       <= rsp_txv_in;
         rsp_txb_ff       <= rsp_txb_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   // transmit store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_count_ff[absp_pkg::TX_AW-1:0]] <= item_data_ff;
      end
      if (state_ff == absp_pkg::ST_TX_READ) begin
         tx_rd_data_ff <= tx_mem[drain_idx_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq_line  = rsp_irq_ff;
   assign rsp_rx_accepted = rsp_acc_ff;
   assign rsp_tx_valid  = rsp_txv_ff;
   assign rsp_tx_byte   = rsp_txb_ff;
   assign rsp_tx_last   = rsp_last_ff;

   // checks
   a_tx_count_room : assert property (@(posedge clock) disable iff (reset)
      tx_count_ff < absp_pkg::TX_CW'(absp_pkg::TX_DEPTH))
      else $error("transmit buffer left full at rest");

   a_rx_read_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == absp_pkg::ST_RX_READ) |=> rsp_valid_ff)
      else $error("popped receive byte not presented");

   a_drain_index : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == absp_pkg::ST_TX_READ) || (state_ff == absp_pkg::ST_TX_SEND)) |->
         ((drain_idx_ff <= drain_last_ff) && (tx_count_ff == '0)))
      else $error("drain index beyond drained bytes");

   a_drain_no_write : assert property (@(posedge clock) disable iff (reset)
      tx_we |-> (state_ff == absp_pkg::ST_IDLE))
      else $error("transmit write during drain");

endmodule

`default_nettype wire

### rtl/absp_rx_buffer.sv
// ----------------------------------------------------------------------------
// absp_rx_buffer
// Receive byte store with chunk loading, read pointer and remaining count.
// Pop data appears in rd_data in the cycle after the pop.
// ----------------------------------------------------------------------------
`default_nettype none

module absp_rx_buffer (
   input  wire                         clock,
   input  wire                         reset,
   input  wire absp_pkg::absp_rx_cmd_type cmd,
   input  wire  [7:0]                  wr_data,
   output absp_pkg::absp_rx_status_type status,
   output logic [7:0]                  rd_data
);

   logic [7:0]                   rx_mem [absp_pkg::RX_DEPTH];
   logic [7:0]                   rd_data_ff;
   logic [absp_pkg::RX_AW-1:0]   read_pos_ff, read_pos_in;
   logic [absp_pkg::RX_CW-1:0]   remaining_ff, remaining_in;
   logic [absp_pkg::RX_AW-1:0]   fill_ff, fill_in;
   logic                         loading_ff, loading_in;
   logic [absp_pkg::RX_AW-1:0]   fill_base;
   logic                         closes;

   // status towards the sequencer
   assign fill_base           = loading_ff ? fill_ff : '0;
   assign status.data_present = (remaining_ff != '0);
   assign status.can_take     = loading_ff || (remaining_ff == '0);
   assign status.fill_last    = (fill_base == absp_pkg::RX_AW'(absp_pkg::RX_DEPTH - 1));
   assign closes              = cmd.chunk_end || status.fill_last;
   assign rd_data             = rd_data_ff;

   // pointer updates
   always_comb begin
      read_pos_in  = read_pos_ff;
      remaining_in = remaining_ff;
      fill_in      = fill_ff;
      loading_in   = loading_ff;
      if (cmd.push) begin
         read_pos_in = '0;
         if (closes) begin
            loading_in   = 1'b0;
            remaining_in = absp_pkg::RX_CW'(fill_base) + absp_pkg::RX_CW'(1);
         end else begin
            loading_in   = 1'b1;
            remaining_in = '0;
            fill_in      = fill_base + absp_pkg::RX_AW'(1);
         end
      end else if (cmd.pop) begin
         read_pos_in  = read_pos_ff + absp_pkg::RX_AW'(1);
         remaining_in = remaining_ff - absp_pkg::RX_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pos_ff  <= '0;
         remaining_ff <= '0;
         fill_ff      <= '0;
         loading_ff   <= 1'b0;
      end else begin
         read_pos_ff  <= read_pos_in;
         remaining_ff <= remaining_in;
         fill_ff      <= fill_in;
         loading_ff   <= loading_in;
      end
   end

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rx_mem[fill_base] <= wr_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= rx_mem[read_pos_ff];
      end
   end

   // checks
   a_loaded_not_loading : assert property (@(posedge clock) disable iff (reset)
      (remaining_ff != '0) |-> !loading_ff)
      else $error("receive bytes readable while a chunk is loading");

   a_push_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> status.can_take)
      else $error("receive byte stored while buffer busy");

   a_pop_when_present : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (status.data_present && !cmd.push))
      else $error("receive pop without data");

   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      (remaining_ff != '0) |->
         ((absp_pkg::RX_CW'(read_pos_ff) + remaining_ff) <=
          absp_pkg::RX_CW'(absp_pkg::RX_DEPTH)))
      else $error("receive read position past stored bytes");

endmodule

`default_nettype wire

### tb/acia_buffered_serial_port_unit_test.sv
// ----------------------------------------------------------------------------
// acia_buffered_serial_port_unit_test
// Self-checking bench for the buffered serial port. A table of hand-picked
// bus and host transfers comes first, some with their results written out.
// A full receive chunk and a full transmit buffer follow, then randomised
// traffic built mostly from whole host chunks, read-backs and text lines.
// Every accepted result is checked in order against the written-out result
// or a software copy of the port. Sender gaps, receiver stalls and one long
// receiver hold-off are applied throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module acia_buffered_serial_port_unit_test;

   // codes the package leaves unnamed
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] TXM_ALT   = 2'd3;

   localparam int RANDOM_ITEMS = 180;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int TAIL_CYCLES  = 40;
   localparam int HOLD_CYCLES  = 250;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       rx_accepted;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
   } port_result_type;

   typedef struct {
      logic [1:0]      op;
      logic            sel;
      logic [7:0]      d;
      logic            ce;
      bit              typed;
      port_result_type want;
   } drill_row_type;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation    = absp_pkg::OP_BUS_READ;
   logic       req_reg_select   = absp_pkg::REG_CTRL;
   logic [7:0] req_data         = 8'h00;
   logic       req_rx_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq_line;
   logic       rsp_rx_accepted;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;

   acia_buffered_serial_port_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_reg_select   (req_reg_select),
      .req_data         (req_data),
      .req_rx_chunk_end (req_rx_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_line     (rsp_irq_line),
      .rsp_rx_accepted  (rsp_rx_accepted),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last)
   );

   // software copy of the port state, reset values
   logic [7:0]                 rx_bytes [absp_pkg::RX_DEPTH];
   logic [absp_pkg::RX_CW-1:0] rx_pos      = '0;
   logic [absp_pkg::RX_CW-1:0] rx_left     = '0;
   logic [absp_pkg::RX_CW-1:0] rx_fill     = '0;
   logic                       rx_filling  = 1'b0;
   logic [7:0]                 tx_bytes [absp_pkg::TX_DEPTH];
   logic [absp_pkg::TX_CW-1:0] tx_fill     = '0;
   logic [1:0]                 tx_mode_now = absp_pkg::TXM_LINE;
   logic                       irq_en_now  = 1'b0;
   logic                       irq_now     = 1'b0;

   port_result_type step_results[$];
   port_result_type port_results_due[$];
   drill_row_type   drill_rows[$];

   int failures   = 0;
   int items_sent = 0;
   int burst_left = 0;

   // ------------------------------------------------------------------
   // port model
   // ------------------------------------------------------------------
   function automatic void push_result(input logic [7:0] rd, input logic acc,
                                       input logic txv, input logic [7:0] b,
                                       input logic last);
      port_result_type r;
      r = '{rd, irq_now, acc, txv, b, last};
      step_results.push_back(r);
   endfunction

   // send the whole transmit buffer as a run of bytes
   function automatic void drain_tx_bytes();
      int n;
      n = int'(tx_fill);
      if (n == 0) begin
         push_result(8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
      end else begin
         for (int i = 0; i < n; i++)
            push_result(8'h00, 1'b0, 1'b1, tx_bytes[i], (i + 1 == n));
      end
      tx_fill = '0;
   endfunction

   function automatic void serial_port_step(input logic [1:0] op, input logic sel,
                                            input logic [7:0] d, input logic ce);
      logic [7:0] rd;
      logic       acc;
      rd  = 8'h00;
      acc = 1'b0;
      step_results.delete();
      case (op)
         absp_pkg::OP_BUS_READ: begin
            if (sel == absp_pkg::REG_CTRL) begin
               if (rx_left != 0) rd = rd | absp_pkg::STAT_RX;
               if (irq_now) rd = rd | absp_pkg::STAT_IRQ;
               irq_now = 1'b0;
            end else if (rx_left != 0) begin
               rd = rx_bytes[rx_pos];
               rx_pos++;
               rx_left--;
            end
            push_result(rd, 1'b0, 1'b0, 8'h00, 1'b1);
         end
         absp_pkg::OP_BUS_WRITE: begin
            if (sel == absp_pkg::REG_CTRL) begin
               if (d[absp_pkg::CTRL_IRQ_EN_BIT]) irq_en_now = 1'b1;
               tx_mode_now = d[1:0];
               if (d[absp_pkg::CTRL_FLUSH_BIT]) drain_tx_bytes();
               else push_result(8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
            end else begin
               if (tx_fill < absp_pkg::TX_DEPTH) begin
                  tx_bytes[tx_fill] = d;
                  tx_fill++;
               end
               if (tx_mode_now == absp_pkg::TXM_NONE ||
                   (tx_mode_now == absp_pkg::TXM_LINE && d == absp_pkg::CHAR_NL) ||
                   tx_fill >= absp_pkg::TX_DEPTH)
                  drain_tx_bytes();
               else
                  push_result(8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
            end
         end
         absp_pkg::OP_HOST_RX: begin
            // taken only when the buffer is empty or a chunk is loading
            if (rx_filling || rx_left == 0) begin
               if (!rx_filling) begin
                  rx_filling = 1'b1;
                  rx_fill    = '0;
                  rx_pos     = '0;
                  rx_left    = '0;
               end
               if (rx_fill < absp_pkg::RX_DEPTH) begin
                  rx_bytes[rx_fill] = d;
                  rx_fill++;
               end
               acc = 1'b1;
               if (ce || rx_fill >= absp_pkg::RX_DEPTH) begin
                  rx_filling = 1'b0;
                  rx_left    = rx_fill;
                  rx_pos     = '0;
                  if (irq_en_now) irq_now = 1'b1;
               end
            end
            push_result(8'h00, acc, 1'b0, 8'h00, 1'b1);
         end
         default: push_result(8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // table helpers
   // ------------------------------------------------------------------
   function automatic port_result_type plain(input logic [7:0] rd, input logic irq,
                                             input logic acc);
      plain = '{rd, irq, acc, 1'b0, 8'h00, 1'b1};
   endfunction

   function automatic logic [7:0] ctrl_byte(input logic irq_en, input logic flush,
                                            input logic [1:0] mode);
      ctrl_byte                            = 8'h00;
      ctrl_byte[absp_pkg::CTRL_IRQ_EN_BIT] = irq_en;
      ctrl_byte[absp_pkg::CTRL_FLUSH_BIT]  = flush;
      ctrl_byte[1:0]                       = mode;
   endfunction

   function automatic void add_drill(input logic [1:0] op, input logic sel,
                                     input logic [7:0] d, input logic ce,
                                     input bit typed, input port_result_type want);
      drill_row_type row;
      row = '{op, sel, d, ce, typed, want};
      drill_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // sender: bursts of transfers with random gaps in between
   // ------------------------------------------------------------------
   task automatic offer_item(input logic [1:0] op, input logic sel, input logic [7:0] d,
                             input logic ce, input bit typed = 1'b0,
                             input port_result_type want = '0);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_reg_select   <= sel;
      req_data         <= d;
      req_rx_chunk_end <= ce;
      do @(posedge clock); while (req_stall);
      serial_port_step(op, sel, d, ce);
      if (typed) port_results_due.push_back(want);
      else foreach (step_results[i]) port_results_due.push_back(step_results[i]);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin : run_limit
      int unsigned cycle_count;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: stall phases of varying density plus one long hold-off
   initial begin : receiver
      int hold_at;
      int hold_left;
      int phase_left;
      int stall_pct;
      int cycles_seen;
      hold_at     = $urandom_range(300, 700);
      hold_left   = 0;
      phase_left  = 0;
      stall_pct   = 0;
      cycles_seen = 0;
      forever begin
         @(posedge clock);
         cycles_seen++;
         if (cycles_seen == hold_at) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  default: stall_pct = 70;
               endcase
               phase_left = $urandom_range(5, 60);
            end
            phase_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // result check against the oldest owed result
   always @(posedge clock) begin : result_check
      port_result_type seen;
      port_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_read_data, rsp_irq_line, rsp_rx_accepted, rsp_tx_valid,
                  rsp_tx_byte, rsp_tx_last};
         if (port_results_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: read_data=%h irq=%b acc=%b txv=%b tx=%h last=%b",
                        seen.read_data, seen.irq_line, seen.rx_accepted, seen.tx_valid,
                        seen.tx_byte, seen.tx_last);
         end else begin
            want = port_results_due.pop_front();
            if (seen !== want) begin
               failures++;
               if (failures <= 10)
                  $display({"result mismatch: read_data %h/%h irq %b/%b acc %b/%b ",
                            "txv %b/%b tx %h/%h last %b/%b (expected/actual)"},
                           want.read_data, seen.read_data, want.irq_line, seen.irq_line,
                           want.rx_accepted, seen.rx_accepted, want.tx_valid, seen.tx_valid,
                           want.tx_byte, seen.tx_byte, want.tx_last, seen.tx_last);
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int n;
      int k;
      int stop_at;
      logic [7:0] b;

      // directed table, from reset
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      // data read with nothing received, chunk end ignored
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, 8'hFF, 1'b1, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_HOST_RX, absp_pkg::REG_DATA, 8'hFF, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b1));
      // chunk still loading: no data present yet
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      // chunk end with interrupts disabled
      add_drill(absp_pkg::OP_HOST_RX, absp_pkg::REG_CTRL, 8'h00, 1'b1, 1,
                plain(8'h00, 1'b0, 1'b1));
      // buffer busy: host byte dropped
      add_drill(absp_pkg::OP_HOST_RX, absp_pkg::REG_DATA, 8'h5A, 1'b1, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0, 1,
                plain(absp_pkg::STAT_RX, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, 8'h00, 1'b0, 1,
                plain(8'hFF, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, 8'h00, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, 8'h00, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                ctrl_byte(1'b1, 1'b0, absp_pkg::TXM_LINE), 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      // chunk end now raises the interrupt
      add_drill(absp_pkg::OP_HOST_RX, absp_pkg::REG_DATA, 8'hA5, 1'b1, 1,
                plain(8'h00, 1'b1, 1'b1));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b1, 1,
                plain(absp_pkg::STAT_IRQ | absp_pkg::STAT_RX, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0, 1,
                plain(absp_pkg::STAT_RX, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, 8'h00, 1'b0, 1,
                plain(8'hA5, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, 8'h41, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, absp_pkg::CHAR_NL, 1'b0, 0,
                '0);
      // flush of an empty transmit buffer
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                ctrl_byte(1'b0, 1'b1, absp_pkg::TXM_LINE), 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      // mode three holds bytes like until-full
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                ctrl_byte(1'b0, 1'b0, TXM_ALT), 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, absp_pkg::CHAR_NL, 1'b1, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, 8'h7F, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                ctrl_byte(1'b0, 1'b1, absp_pkg::TXM_NONE), 1'b0, 0, '0);
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, 8'h33, 1'b0, 1,
                '{8'h00, 1'b0, 1'b0, 1'b1, 8'h33, 1'b1});
      add_drill(OP_UNUSED, absp_pkg::REG_DATA, 8'hFF, 1'b1, 1,
                plain(8'h00, 1'b0, 1'b0));
      // ignored control bits set
      add_drill(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                ctrl_byte(1'b0, 1'b0, absp_pkg::TXM_FULL) | 8'h78, 1'b0, 1,
                plain(8'h00, 1'b0, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[i])
         offer_item(drill_rows[i].op, drill_rows[i].sel, drill_rows[i].d, drill_rows[i].ce,
                    drill_rows[i].typed, drill_rows[i].want);

      // one chunk that fills every receive slot, then read it all back
      for (int i = 0; i < absp_pkg::RX_DEPTH; i++)
         offer_item(absp_pkg::OP_HOST_RX, absp_pkg::REG_DATA,
                    8'($urandom_range(0, 255)), 1'b0);
      offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0);
      for (int i = 0; i <= absp_pkg::RX_DEPTH; i++)
         offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA,
                    8'($urandom_range(0, 255)), 1'b0);

      // transmit buffer filled to the top in until-full mode
      offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                 ctrl_byte(1'b0, 1'b0, absp_pkg::TXM_FULL), 1'b0);
      for (int i = 0; i < absp_pkg::TX_DEPTH; i++)
         offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA,
                    8'($urandom_range(0, 255)), 1'b0);

      // random traffic, mostly whole chunks and text lines
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = $urandom_range(1, 8);
               for (int i = 0; i < n; i++)
                  offer_item(absp_pkg::OP_HOST_RX, 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)),
                             (i == n - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
               if ($urandom_range(0, 1))
                  offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               k = n + $urandom_range(0, 1);
               for (int i = 0; i < k; i++)
                  offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            3: offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_CTRL,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            4, 5: begin
               n = $urandom_range(0, 6);
               for (int i = 0; i < n; i++)
                  offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA,
                             8'($urandom_range(0, 255)), 1'b0);
               offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA, absp_pkg::CHAR_NL,
                          1'($urandom_range(0, 1)));
            end
            6: begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++)
                  offer_item(absp_pkg::OP_BUS_WRITE, absp_pkg::REG_DATA,
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            7: offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_CTRL, 8'h00, 1'b0);
            8: begin
               // noise: unused operation, stray reads and host bytes
               b = 8'($urandom_range(0, 255));
               case ($urandom_range(0, 2))
                  0: offer_item(OP_UNUSED, 1'($urandom_range(0, 1)), b,
                                1'($urandom_range(0, 1)));
                  1: offer_item(absp_pkg::OP_BUS_READ, absp_pkg::REG_DATA, b,
                                1'($urandom_range(0, 1)));
                  default: offer_item(absp_pkg::OP_HOST_RX, 1'($urandom_range(0, 1)), b,
                                      1'($urandom_range(0, 1)));
               endcase
            end
            default: offer_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         endcase
      end
      req_valid <= 1'b0;

      // wait for the last results, then a short quiet tail
      while (port_results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      failures = failures + port_results_due.size();

      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
